// ===== src/sept_pkg.sv =====
package sept_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int FRACTION_BITS = 16;

	localparam int ELAPSED_W = 25;
	localparam int DUR_W = 24;
	localparam int COORD_W = 32;
	localparam int STEP_W = 16;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [7:0] TAYLOR_DIV [7] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};

	localparam logic [1:0] MODE_IN = 2'd0;
	localparam logic [1:0] MODE_OUT = 2'd1;
	localparam logic [1:0] MODE_INOUT = 2'd2;
	localparam logic [1:0] MODE_ZERO = 2'd3;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_RESTART = 1'b1;

	localparam logic [2:0] REG_EASE_MODE = 3'd0;
	localparam logic [2:0] REG_START_X = 3'd1;
	localparam logic [2:0] REG_START_Y = 3'd2;
	localparam logic [2:0] REG_START_Z = 3'd3;
	localparam logic [2:0] REG_END_X = 3'd4;
	localparam logic [2:0] REG_END_Y = 3'd5;
	localparam logic [2:0] REG_END_Z = 3'd6;
	localparam logic [2:0] REG_DURATION = 3'd7;

	typedef struct packed {
		logic load;
		logic step;
		logic w_bit;
		logic round;
		logic finish;
		logic from_end;
	} lane_ctl_t;

endpackage

// ===== src/sept_div.sv =====
module sept_div #(
	parameter int FracBits = sept_pkg::FRACTION_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [sept_pkg::ELAPSED_W-1:0]   dividend,
	input  logic [sept_pkg::DUR_W-1:0]       divisor,
	output logic                             done,
	output logic [FracBits:0]                quot
);

	localparam int CntW = $clog2(FracBits + 2);
	localparam int RemW = sept_pkg::ELAPSED_W;

	logic [RemW-1:0]     rem_q;
	logic [FracBits:0]   quot_q;
	logic [CntW-1:0]     cnt_q;
	logic                busy_q;
	logic                done_q;
	logic                ge;
	logic [RemW-1:0]     rem_sub;
	logic [RemW-1:0]     rem_next;

	always_comb begin
		ge = rem_q >= RemW'(divisor);
		rem_sub = rem_q - RemW'(divisor);
		rem_next = ge ? rem_sub : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CntW'(FracBits + 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q <= {rem_next[RemW-2:0], 1'b0};
			quot_q <= {quot_q[FracBits-1:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== src/sept_rom.sv =====
module sept_rom #(
	parameter int Depth = sept_pkg::TABLE_DEPTH,
	parameter int FracBits = sept_pkg::FRACTION_BITS
) (
	input  logic                           clk,
	input  logic [$clog2(Depth + 1)-1:0]   idx,
	output logic [FracBits:0]              data
);

	typedef logic [FracBits:0] entry_t;
	typedef entry_t tab_t [Depth + 1];

	function automatic tab_t build_tab();
		tab_t t;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] e;
		logic signed [63:0] sum;
		for (int i = 0; i <= Depth; i++) begin
			x = (sept_pkg::HALF_PI_Q30 * 64'(i)) / 64'(Depth);
			x2 = (x * x) >> 30;
			term = x;
			sum = $signed(x);
			for (int k = 1; k <= 7; k++) begin
				term = (term * x2) >> 30;
				term = term / 64'(sept_pkg::TAYLOR_DIV[k-1]);
				if (k % 2 == 1) begin
					sum = sum - $signed(term);
				end else begin
					sum = sum + $signed(term);
				end
			end
			if (sum < 0) begin
				sum = '0;
			end
			e = (($unsigned(sum) << FracBits) + (64'd1 << 29)) >> 30;
			if (e > (64'd1 << FracBits)) begin
				e = 64'd1 << FracBits;
			end
			t[i] = e[FracBits:0];
		end
		t[Depth] = entry_t'(1) << FracBits;
		return t;
	endfunction

	localparam tab_t Tab = build_tab();

	logic [FracBits:0] data_q;

	always_ff @(posedge clk) begin
		data_q <= Tab[idx];
	end

	assign data = data_q;

endmodule

// ===== src/sept_lane.sv =====
module sept_lane #(
	parameter int FracBits = sept_pkg::FRACTION_BITS
) (
	input  logic                                clk,
	input  sept_pkg::lane_ctl_t                 ctl,
	input  logic signed [sept_pkg::COORD_W-1:0] start_pos,
	input  logic signed [sept_pkg::COORD_W-1:0] end_pos,
	output logic signed [sept_pkg::COORD_W-1:0] pos
);

	localparam int AccW = FracBits + 34;
	localparam logic signed [AccW-1:0] Half = AccW'(1) << (FracBits - 1);

	logic signed [32:0]      diff_q;
	logic signed [AccW-1:0]  acc_q;
	logic signed [34:0]      rnd_q;
	logic signed [31:0]      pos_q;
	logic signed [AccW-1:0]  addend;
	logic signed [AccW-1:0]  rounded;
	logic signed [34:0]      sum;

	always_comb begin
		addend = AccW'(ctl.w_bit ? diff_q : 33'sd0);
		rounded = (acc_q + Half) >>> FracBits;
		sum = ctl.from_end ? 35'(end_pos) - rnd_q : 35'(start_pos) + rnd_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			diff_q <= 33'(end_pos) - 33'(start_pos);
			acc_q <= '0;
		end else if (ctl.step) begin
			acc_q <= (acc_q <<< 1) + addend;
		end
		if (ctl.round) begin
			rnd_q <= 35'(rounded);
		end
		if (ctl.finish) begin
			if (sum > 35'sd2147483647) begin
				pos_q <= 32'sh7FFFFFFF;
			end else if (sum < -35'sd2147483648) begin
				pos_q <= 32'sh80000000;
			end else begin
				pos_q <= sum[31:0];
			end
		end
	end

	assign pos = pos_q;

endmodule

// ===== src/sine_ease_position_tween.sv =====
// Sine-eased position tween for a point in three dimensions, Q16.16 coordinates.
// Items enter on the req channel (req_valid, req_stall; fields kind and
// time_step) and results leave on the res channel (res_valid, res_stall;
// fields pos_x, pos_y, pos_z and finished). The start point, end point,
// duration and easing curve are written through the APB-style port; the user
// must write them only while the block is idle, which the block itself does
// not enforce. pready is always high. A restart item arms the block and gives
// no result. A tick while disarmed gives no result. A tick that runs past the
// duration gives the end point with finished set; res_valid rises after the
// CHECK and EMIT states, and the zero mode takes the same path. For a curve
// result the ratio comes from a divider that gives one quotient bit per cycle,
// and the three coordinates are then scaled by a multiplier that takes one
// weight bit per cycle in each of three lanes. One item is worked on at a time;
// req_stall is high while it is in progress, so the next item is taken at the
// earliest in the same cycle that res_valid rises.
// Results sit in an output register, so a new item is taken while a result
// waits under res_stall; the next result then waits until that one is taken.
// Reset clears the configuration to its defaults, disarms the block and
// drops any pending result.
module sine_ease_position_tween #(
	parameter int TableDepth = sept_pkg::TABLE_DEPTH,
	parameter int FracBits = sept_pkg::FRACTION_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [sept_pkg::ADDR_W-1:0]         paddr,
	input  logic [sept_pkg::DATA_W-1:0]         pwdata,
	output logic [sept_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic                                kind,
	input  logic [sept_pkg::STEP_W-1:0]         time_step,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic signed [sept_pkg::COORD_W-1:0] pos_x,
	output logic signed [sept_pkg::COORD_W-1:0] pos_y,
	output logic signed [sept_pkg::COORD_W-1:0] pos_z,
	output logic                                finished
);

	localparam int EW = sept_pkg::ELAPSED_W;
	localparam int DW = sept_pkg::DUR_W;
	localparam int CW = sept_pkg::COORD_W;
	localparam int IdxW = $clog2(TableDepth + 1);
	localparam int ProdW = FracBits + 1 + IdxW;
	localparam int CntW = $clog2(FracBits + 2);
	localparam logic [FracBits:0] One = (FracBits + 1)'(1) << FracBits;
	localparam logic [FracBits+1:0] One2 = (FracBits + 2)'(1) << FracBits;
	localparam logic [ProdW-1:0] HalfP = ProdW'(1) << (FracBits - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_DIV, S_PSEL, S_IDX, S_ROM, S_WGT, S_MUL, S_RND, S_FIN, S_EMIT
	} state_t;

	typedef enum logic [1:0] {SEL_END, SEL_ZERO, SEL_CURVE} sel_t;

	state_t state_q;
	sel_t   sel_q;

	logic [1:0]           ease_mode_q;
	logic signed [CW-1:0] start_x_q, start_y_q, start_z_q;
	logic signed [CW-1:0] end_x_q, end_y_q, end_z_q;
	logic [DW-1:0]        duration_q;

	logic                 armed_q;
	logic [EW-1:0]        elapsed_q;

	logic [FracBits:0]    p_q;
	logic                 neg_q;
	logic [IdxW-1:0]      idx_q;
	logic [FracBits:0]    w_sr_q;
	logic [CntW-1:0]      mcnt_q;

	logic                 res_valid_q;
	logic signed [CW-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic                 finished_q;

	logic                 cfg_wr;
	logic [2:0]           cfg_idx;
	logic                 accept;
	logic [EW:0]          elapsed_sum;
	logic [EW-1:0]        elapsed_next;
	logic [DW-1:0]        dur;
	logic                 over;
	logic                 div_start;
	logic                 div_done;
	logic [FracBits:0]    quot;
	logic [FracBits+1:0]  a2;
	logic [FracBits+1:0]  a2_lo;
	logic [FracBits+1:0]  a2_hi;
	logic [FracBits:0]    p_d;
	logic                 neg_d;
	logic [ProdW-1:0]     scaled;
	logic [ProdW-1:0]     scaled_idx;
	logic [IdxW-1:0]      idx_d;
	logic [FracBits:0]    rom_data;
	logic [FracBits+1:0]  wsum;
	logic [FracBits:0]    w_d;
	logic                 out_free;
	logic signed [CW-1:0] lane_x, lane_y, lane_z;
	sept_pkg::lane_ctl_t  lane_ctl;

	assign cfg_wr = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[4:2];
	assign pready = 1'b1;

	always_comb begin
		case (cfg_idx)
			sept_pkg::REG_EASE_MODE: prdata = 32'(ease_mode_q);
			sept_pkg::REG_START_X:   prdata = start_x_q;
			sept_pkg::REG_START_Y:   prdata = start_y_q;
			sept_pkg::REG_START_Z:   prdata = start_z_q;
			sept_pkg::REG_END_X:     prdata = end_x_q;
			sept_pkg::REG_END_Y:     prdata = end_y_q;
			sept_pkg::REG_END_Z:     prdata = end_z_q;
			sept_pkg::REG_DURATION:  prdata = 32'(duration_q);
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ease_mode_q <= sept_pkg::MODE_IN;
			start_x_q <= '0;
			start_y_q <= '0;
			start_z_q <= '0;
			end_x_q <= '0;
			end_y_q <= '0;
			end_z_q <= '0;
			duration_q <= DW'(1);
		end else if (cfg_wr) begin
			case (cfg_idx)
				sept_pkg::REG_EASE_MODE: ease_mode_q <= pwdata[1:0];
				sept_pkg::REG_START_X:   start_x_q <= pwdata;
				sept_pkg::REG_START_Y:   start_y_q <= pwdata;
				sept_pkg::REG_START_Z:   start_z_q <= pwdata;
				sept_pkg::REG_END_X:     end_x_q <= pwdata;
				sept_pkg::REG_END_Y:     end_y_q <= pwdata;
				sept_pkg::REG_END_Z:     end_z_q <= pwdata;
				sept_pkg::REG_DURATION:  duration_q <= pwdata[DW-1:0];
				default:                 ease_mode_q <= ease_mode_q;
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign accept = req_valid && !req_stall;
	assign out_free = !res_valid_q || !res_stall;

	always_comb begin
		elapsed_sum = (EW + 1)'(elapsed_q) + (EW + 1)'(time_step);
		elapsed_next = elapsed_sum[EW] ? sept_pkg::ELAPSED_MAX : elapsed_sum[EW-1:0];
		dur = (duration_q == '0) ? DW'(1) : duration_q;
		over = elapsed_q > EW'(dur);
		div_start = (state_q == S_CHECK) && !over && (ease_mode_q != sept_pkg::MODE_ZERO);
	end

	always_comb begin
		a2 = {quot, 1'b0};
		a2_lo = One2 - a2;
		a2_hi = a2 - One2;
		neg_d = 1'b0;
		case (ease_mode_q)
			sept_pkg::MODE_IN:  p_d = One - quot;
			sept_pkg::MODE_OUT: p_d = quot;
			default: begin
				if (a2 <= One2) begin
					p_d = a2_lo[FracBits:0];
				end else begin
					p_d = a2_hi[FracBits:0];
					neg_d = 1'b1;
				end
			end
		endcase
	end

	always_comb begin
		scaled = ProdW'(p_q) * ProdW'(TableDepth) + HalfP;
		scaled_idx = scaled >> FracBits;
		idx_d = (scaled_idx > ProdW'(TableDepth)) ? IdxW'(TableDepth)
			: scaled_idx[IdxW-1:0];
	end

	always_comb begin
		wsum = neg_q ? One2 + (FracBits + 2)'(rom_data) : One2 - (FracBits + 2)'(rom_data);
		case (ease_mode_q)
			sept_pkg::MODE_IN:  w_d = rom_data;
			sept_pkg::MODE_OUT: w_d = rom_data;
			default:            w_d = wsum[FracBits+1:1];
		endcase
	end

	always_comb begin
		lane_ctl.load = (state_q == S_WGT);
		lane_ctl.step = (state_q == S_MUL);
		lane_ctl.w_bit = w_sr_q[FracBits];
		lane_ctl.round = (state_q == S_RND);
		lane_ctl.finish = (state_q == S_FIN);
		lane_ctl.from_end = (ease_mode_q == sept_pkg::MODE_IN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q <= SEL_ZERO;
			armed_q <= 1'b0;
			elapsed_q <= '0;
			mcnt_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (kind == sept_pkg::KIND_RESTART) begin
							elapsed_q <= '0;
							armed_q <= 1'b1;
						end else if (armed_q) begin
							elapsed_q <= elapsed_next;
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (over) begin
						sel_q <= SEL_END;
						armed_q <= 1'b0;
						state_q <= S_EMIT;
					end else if (ease_mode_q == sept_pkg::MODE_ZERO) begin
						sel_q <= SEL_ZERO;
						state_q <= S_EMIT;
					end else begin
						sel_q <= SEL_CURVE;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_PSEL;
					end
				end
				S_PSEL: state_q <= S_IDX;
				S_IDX:  state_q <= S_ROM;
				S_ROM:  state_q <= S_WGT;
				S_WGT: begin
					mcnt_q <= CntW'(FracBits + 1);
					state_q <= S_MUL;
				end
				S_MUL: begin
					mcnt_q <= mcnt_q - CntW'(1);
					if (mcnt_q == CntW'(1)) begin
						state_q <= S_RND;
					end
				end
				S_RND: state_q <= S_FIN;
				S_FIN: state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PSEL) begin
			p_q <= p_d;
			neg_q <= neg_d;
		end
		if (state_q == S_IDX) begin
			idx_q <= idx_d;
		end
		if (state_q == S_WGT) begin
			w_sr_q <= w_d;
		end else if (state_q == S_MUL) begin
			w_sr_q <= {w_sr_q[FracBits-1:0], 1'b0};
		end
		if (state_q == S_EMIT && out_free) begin
			case (sel_q)
				SEL_END: begin
					pos_x_q <= end_x_q;
					pos_y_q <= end_y_q;
					pos_z_q <= end_z_q;
					finished_q <= 1'b1;
				end
				SEL_CURVE: begin
					pos_x_q <= lane_x;
					pos_y_q <= lane_y;
					pos_z_q <= lane_z;
					finished_q <= 1'b0;
				end
				default: begin
					pos_x_q <= '0;
					pos_y_q <= '0;
					pos_z_q <= '0;
					finished_q <= 1'b0;
				end
			endcase
		end
	end

	sept_div #(
		.FracBits(FracBits)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (elapsed_q),
		.divisor  (dur),
		.done     (div_done),
		.quot     (quot)
	);

	sept_rom #(
		.Depth    (TableDepth),
		.FracBits (FracBits)
	) u_rom (
		.clk  (clk),
		.idx  (idx_q),
		.data (rom_data)
	);

	sept_lane #(
		.FracBits(FracBits)
	) u_lane_x (
		.clk       (clk),
		.ctl       (lane_ctl),
		.start_pos (start_x_q),
		.end_pos   (end_x_q),
		.pos       (lane_x)
	);

	sept_lane #(
		.FracBits(FracBits)
	) u_lane_y (
		.clk       (clk),
		.ctl       (lane_ctl),
		.start_pos (start_y_q),
		.end_pos   (end_y_q),
		.pos       (lane_y)
	);

	sept_lane #(
		.FracBits(FracBits)
	) u_lane_z (
		.clk       (clk),
		.ctl       (lane_ctl),
		.start_pos (start_z_q),
		.end_pos   (end_z_q),
		.pos       (lane_z)
	);

	assign res_valid = res_valid_q;
	assign pos_x = pos_x_q;
	assign pos_y = pos_y_q;
	assign pos_z = pos_z_q;
	assign finished = finished_q;

endmodule

// ===== verif/sine_ease_position_tween_test.sv =====
`timescale 1ns / 1ps

module sine_ease_position_tween_test;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 40;
	localparam int TARGET_ITEMS = 950;
	localparam int QUIET_FROM = 820;
	localparam longint unsigned UNIT_Q = 64'd1 << sept_pkg::FRACTION_BITS;

	typedef struct packed {
		logic signed [sept_pkg::COORD_W-1:0] x;
		logic signed [sept_pkg::COORD_W-1:0] y;
		logic signed [sept_pkg::COORD_W-1:0] z;
		logic                                fin;
	} position_t;

	logic                                clk;
	logic                                arst_n;
	logic                                psel;
	logic                                penable;
	logic                                pwrite;
	logic [sept_pkg::ADDR_W-1:0]         paddr;
	logic [sept_pkg::DATA_W-1:0]         pwdata;
	logic [sept_pkg::DATA_W-1:0]         prdata;
	logic                                pready;
	logic                                req_valid;
	logic                                req_stall;
	logic                                kind;
	logic [sept_pkg::STEP_W-1:0]         time_step;
	logic                                res_valid;
	logic                                res_stall;
	logic signed [sept_pkg::COORD_W-1:0] pos_x;
	logic signed [sept_pkg::COORD_W-1:0] pos_y;
	logic signed [sept_pkg::COORD_W-1:0] pos_z;
	logic                                finished;

	logic [1:0]                          tw_mode;
	logic signed [sept_pkg::COORD_W-1:0] start_pt [3];
	logic signed [sept_pkg::COORD_W-1:0] target_pt [3];
	logic [sept_pkg::DUR_W-1:0]          tw_duration;
	bit                                  tw_armed;
	logic [sept_pkg::ELAPSED_W-1:0]      tw_elapsed;
	longint unsigned                     sine_lut [sept_pkg::TABLE_DEPTH+1];

	position_t expected_positions [$];
	int        mismatch_count;
	int        counted_items;
	bit        quiet;

	sine_ease_position_tween uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.kind(kind),
		.time_step(time_step),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.finished(finished)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint taylor_sin(longint unsigned x);
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int k = 1; k <= 7; k++) begin
			term = (term * x2) >> 30;
			term = term / ((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				sum -= longint'(term);
			end else begin
				sum += longint'(term);
			end
		end
		return (sum < 0) ? 0 : sum;
	endfunction

	function automatic longint quarter_sine(longint unsigned p);
		longint unsigned idx;
		idx = (p * sept_pkg::TABLE_DEPTH + (UNIT_Q >> 1)) >> sept_pkg::FRACTION_BITS;
		if (idx > sept_pkg::TABLE_DEPTH) begin
			idx = sept_pkg::TABLE_DEPTH;
		end
		return longint'(sine_lut[idx]);
	endfunction

	function automatic logic signed [sept_pkg::COORD_W-1:0] clamp32(longint v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end
		if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// Advances the tween by one item; returns 1 when the item yields a position.
	function automatic bit predict_position(input logic k,
			input logic [sept_pkg::STEP_W-1:0] st, output position_t r);
		longint unsigned                     total;
		longint unsigned                     dur;
		longint unsigned                     ratio;
		longint unsigned                     q;
		longint                              w;
		longint                              c;
		longint                              diff;
		longint                              t;
		longint                              p;
		logic signed [sept_pkg::COORD_W-1:0] coord [3];
		r = '0;
		if (k == sept_pkg::KIND_RESTART) begin
			tw_elapsed = '0;
			tw_armed = 1'b1;
			return 1'b0;
		end
		if (!tw_armed) begin
			return 1'b0;
		end
		total = 64'(tw_elapsed);
		total += 64'(st);
		if (total > 64'(sept_pkg::ELAPSED_MAX)) begin
			total = 64'(sept_pkg::ELAPSED_MAX);
		end
		tw_elapsed = total[sept_pkg::ELAPSED_W-1:0];
		dur = (tw_duration == 0) ? 64'd1 : 64'(tw_duration);
		if (total > dur) begin
			r.x = target_pt[0];
			r.y = target_pt[1];
			r.z = target_pt[2];
			r.fin = 1'b1;
			tw_armed = 1'b0;
			return 1'b1;
		end
		if (tw_mode == sept_pkg::MODE_ZERO) begin
			return 1'b1;
		end
		ratio = (total << sept_pkg::FRACTION_BITS) / dur;
		if (ratio > UNIT_Q) begin
			ratio = UNIT_Q;
		end
		case (tw_mode)
			sept_pkg::MODE_IN: w = quarter_sine(UNIT_Q - ratio);
			sept_pkg::MODE_OUT: w = quarter_sine(ratio);
			default: begin
				q = 2 * ratio;
				c = (q <= UNIT_Q) ? quarter_sine(UNIT_Q - q) : -quarter_sine(q - UNIT_Q);
				w = (longint'(UNIT_Q) - c) / 2;
			end
		endcase
		for (int i = 0; i < 3; i++) begin
			diff = longint'(target_pt[i]) - longint'(start_pt[i]);
			t = (diff * w + longint'(UNIT_Q >> 1)) >>> sept_pkg::FRACTION_BITS;
			if (tw_mode == sept_pkg::MODE_IN) begin
				p = longint'(target_pt[i]) - t;
			end else begin
				p = longint'(start_pt[i]) + t;
			end
			coord[i] = clamp32(p);
		end
		r.x = coord[0];
		r.y = coord[1];
		r.z = coord[2];
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%s", msg);
		end
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [sept_pkg::DATA_W-1:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			sept_pkg::REG_EASE_MODE: tw_mode = value[1:0];
			sept_pkg::REG_START_X: start_pt[0] = value;
			sept_pkg::REG_START_Y: start_pt[1] = value;
			sept_pkg::REG_START_Z: start_pt[2] = value;
			sept_pkg::REG_END_X: target_pt[0] = value;
			sept_pkg::REG_END_Y: target_pt[1] = value;
			sept_pkg::REG_END_Z: target_pt[2] = value;
			default: tw_duration = value[sept_pkg::DUR_W-1:0];
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic send_item(input logic k, input logic [sept_pkg::STEP_W-1:0] st);
		position_t r;
		int        gap;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_valid = 1'b0;
			gap = $urandom_range(1, 10);
			repeat (gap) @(negedge clk);
		end
		req_valid = 1'b1;
		kind = k;
		time_step = st;
		do @(posedge clk); while (req_stall);
		if (predict_position(k, st, r)) begin
			expected_positions.push_back(r);
			counted_items++;
		end else if (k == sept_pkg::KIND_RESTART) begin
			counted_items++;
		end
	endtask

	// A restart or an ignored tick gives no result, so the pause covers a curve in flight.
	task automatic quiesce_block();
		@(negedge clk);
		req_valid = 1'b0;
		while (expected_positions.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [sept_pkg::DATA_W-1:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
			default: return $urandom();
		endcase
	endfunction

	task automatic test_power_on_defaults();
		send_item(sept_pkg::KIND_TICK, 16'hFFFF);
		send_item(sept_pkg::KIND_RESTART, 16'd0);
		send_item(sept_pkg::KIND_TICK, 16'd0);
		send_item(sept_pkg::KIND_TICK, 16'd1);
		send_item(sept_pkg::KIND_TICK, 16'd1);
		send_item(sept_pkg::KIND_TICK, 16'd3);
	endtask

	task automatic test_each_curve();
		logic [1:0] curve_modes [4];
		curve_modes = '{sept_pkg::MODE_IN, sept_pkg::MODE_OUT, sept_pkg::MODE_INOUT,
			sept_pkg::MODE_ZERO};
		quiesce_block();
		apb_write(sept_pkg::REG_START_X, 32'h8000_0000);
		apb_write(sept_pkg::REG_END_X, 32'h7FFF_FFFF);
		apb_write(sept_pkg::REG_START_Y, 32'h7FFF_FFFF);
		apb_write(sept_pkg::REG_END_Y, 32'h8000_0000);
		apb_write(sept_pkg::REG_START_Z, 32'h0003_8000);
		apb_write(sept_pkg::REG_END_Z, 32'hFFF0_4000);
		apb_write(sept_pkg::REG_DURATION, 32'd1000);
		foreach (curve_modes[i]) begin
			quiesce_block();
			apb_write(sept_pkg::REG_EASE_MODE, {30'd0, curve_modes[i]});
			send_item(sept_pkg::KIND_RESTART, 16'hFFFF);
			send_item(sept_pkg::KIND_TICK, 16'd500);
			send_item(sept_pkg::KIND_TICK, 16'd500);
			send_item(sept_pkg::KIND_TICK, 16'hFFFF);
		end
	endtask

	task automatic test_duration_limits();
		quiesce_block();
		apb_write(sept_pkg::REG_EASE_MODE, {30'd0, sept_pkg::MODE_OUT});
		apb_write(sept_pkg::REG_DURATION, 32'hFF00_0000);
		send_item(sept_pkg::KIND_RESTART, 16'd0);
		send_item(sept_pkg::KIND_TICK, 16'd0);
		send_item(sept_pkg::KIND_TICK, 16'd1);
		send_item(sept_pkg::KIND_TICK, 16'd1);
		quiesce_block();
		apb_write(sept_pkg::REG_DURATION, 32'h00FF_FFFF);
		send_item(sept_pkg::KIND_RESTART, 16'd0);
		send_item(sept_pkg::KIND_TICK, 16'hFFFF);
	endtask

	task automatic run_random_tween();
		longint unsigned             dur;
		longint unsigned             hi;
		int                          ticks;
		int                          n;
		logic [sept_pkg::STEP_W-1:0] st;
		if ($urandom_range(0, 7) == 0) begin
			send_item(sept_pkg::KIND_TICK, 16'($urandom()));
		end
		send_item(sept_pkg::KIND_RESTART, 16'($urandom()));
		ticks = $urandom_range(10, 60);
		n = $urandom_range(1, 20);
		dur = (tw_duration == 0) ? 64'd1 : 64'(tw_duration);
		hi = (2 * dur) / n + 1;
		if (hi > 65535) begin
			hi = 65535;
		end
		while (tw_armed && ticks > 0) begin
			if ($urandom_range(0, 15) == 0) begin
				st = 16'($urandom());
			end else begin
				st = 16'($urandom_range(0, int'(hi)));
			end
			if ($urandom_range(0, 39) == 0) begin
				send_item(sept_pkg::KIND_RESTART, st);
			end else begin
				send_item(sept_pkg::KIND_TICK, st);
			end
			ticks--;
		end
	endtask

	task automatic test_random_tweens();
		logic [sept_pkg::DATA_W-1:0] word;
		logic [sept_pkg::DUR_W-1:0]  dur_w;
		while (counted_items < TARGET_ITEMS) begin
			quiesce_block();
			word = $urandom();
			word[1:0] = 2'($urandom_range(0, 3));
			apb_write(sept_pkg::REG_EASE_MODE, word);
			apb_write(sept_pkg::REG_START_X, pick_coord());
			apb_write(sept_pkg::REG_START_Y, pick_coord());
			apb_write(sept_pkg::REG_START_Z, pick_coord());
			apb_write(sept_pkg::REG_END_X, pick_coord());
			apb_write(sept_pkg::REG_END_Y, pick_coord());
			apb_write(sept_pkg::REG_END_Z, pick_coord());
			case ($urandom_range(0, 9))
				0: dur_w = 24'd1;
				1: dur_w = 24'hFF_FFFF;
				2: dur_w = 24'($urandom_range(1, 24'hFF_FFFF));
				default: dur_w = 24'($urandom_range(1, 4000));
			endcase
			word = $urandom();
			word[sept_pkg::DUR_W-1:0] = dur_w;
			apb_write(sept_pkg::REG_DURATION, word);
			repeat ($urandom_range(2, 6)) begin
				if (counted_items >= QUIET_FROM) begin
					quiet = 1'b1;
				end
				run_random_tween();
			end
		end
	endtask

	initial begin
		int burst;
		burst = 0;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (quiet) begin
				burst = 0;
			end else if (burst == 0 && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 10);
			end
			res_stall = (burst > 0);
			if (burst > 0) begin
				burst--;
			end
		end
	end

	initial begin
		position_t want;
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall) begin
				if (expected_positions.size() == 0) begin
					report_mismatch($sformatf("unexpected item: x=%0d y=%0d z=%0d finished=%0b",
						pos_x, pos_y, pos_z, finished));
				end else begin
					want = expected_positions.pop_front();
					if (pos_x !== want.x || pos_y !== want.y || pos_z !== want.z ||
							finished !== want.fin) begin
						report_mismatch($sformatf(
							"mismatch: expected x=%0d y=%0d z=%0d fin=%0b, got x=%0d y=%0d z=%0d fin=%0b",
							want.x, want.y, want.z, want.fin, pos_x, pos_y, pos_z, finished));
					end
				end
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (res_valid && !res_stall) ||
					(psel && penable && pready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("[sine_ease_position_tween] ERROR");
		$finish;
	end

	initial begin
		longint unsigned x;
		longint unsigned s;
		longint unsigned e;
		for (int i = 0; i <= sept_pkg::TABLE_DEPTH; i++) begin
			x = (sept_pkg::HALF_PI_Q30 * i) / sept_pkg::TABLE_DEPTH;
			s = taylor_sin(x);
			e = (s * UNIT_Q + (64'd1 << 29)) >> 30;
			if (e > UNIT_Q) begin
				e = UNIT_Q;
			end
			sine_lut[i] = e;
		end
		sine_lut[sept_pkg::TABLE_DEPTH] = UNIT_Q;
		tw_mode = sept_pkg::MODE_IN;
		for (int i = 0; i < 3; i++) begin
			start_pt[i] = '0;
			target_pt[i] = '0;
		end
		tw_duration = sept_pkg::DUR_W'(1);
		tw_armed = 1'b0;
		tw_elapsed = '0;
		mismatch_count = 0;
		counted_items = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_valid = 1'b0;
		kind = sept_pkg::KIND_TICK;
		time_step = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_power_on_defaults();
		test_each_curve();
		test_duration_limits();
		test_random_tweens();
		quiet = 1'b1;
		quiesce_block();
		if (mismatch_count == 0 && expected_positions.size() == 0) begin
			$display("[sine_ease_position_tween] OK");
		end else begin
			$display("[sine_ease_position_tween] ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/sept_pkg.sv
src/sept_div.sv
src/sept_rom.sv
src/sept_lane.sv
src/sine_ease_position_tween.sv
verif/sine_ease_position_tween_test.sv
